>>> sv/ebcs_pkg.sv
// Shared types and constants of the bad-character search block.
`default_nettype none

package ebcs_pkg;

    localparam int MAX_PATTERN_DEF  = 16;
    localparam int WINDOW_DEPTH_DEF = 32;

    localparam int POS_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd2;

    localparam logic [POS_W-1:0] POS_SAT = 16'hFFFF;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_BAD,
        S_SHIFT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       shift;
        logic [7:0] text_byte;
    } t_chain_ctl;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] position;
        logic             found;
    } t_result;

endpackage

`default_nettype wire

>>> sv/ebcs_cell.sv
// One window cell: holds a text byte, compares it with its pattern byte and that with the mismatch byte.
`default_nettype none

module ebcs_cell #(
    parameter int IDX = 0,
    parameter int FW  = 5
) (
    input  wire logic                i_clk,
    input  wire ebcs_pkg::t_chain_ctl i_ctl,
    input  wire logic [FW-1:0]       i_fill,
    input  wire logic [7:0]          i_next_byte,
    input  wire logic [7:0]          i_pat_byte,
    input  wire logic [FW-1:0]       i_m,
    input  wire logic [FW-1:0]       i_j,
    input  wire logic [7:0]          i_c,
    output logic [7:0]               o_byte,
    output logic                     o_mis,
    output logic                     o_eq
);
    import ebcs_pkg::*;

    localparam logic [FW-1:0] MY_IDX = FW'(IDX);

    logic [7:0] r_byte;
    logic [7:0] n_byte;
    logic       w_load_here;

    assign w_load_here = i_ctl.load && (i_fill == MY_IDX);

    always_comb begin
        if (w_load_here) begin
            n_byte = i_ctl.text_byte;
        end else if (i_ctl.shift) begin
            n_byte = i_next_byte;
        end else begin
            n_byte = r_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;
    assign o_mis  = (MY_IDX < i_m) && (r_byte != i_pat_byte);
    assign o_eq   = (MY_IDX < i_j) && (i_pat_byte == i_c);

endmodule

`default_nettype wire

>>> sv/ebcs_ctrl.sv
// Sequencer of the search: takes items, runs compares, skips and shifts, forms results.
`default_nettype none

module ebcs_ctrl #(
    parameter int N_CELLS = 16,
    parameter int FW      = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire logic [7:0]             i_text_byte,
    input  wire logic                   i_last_byte,
    output logic                        o_stall,
    input  wire logic [FW-1:0]          i_m,
    input  wire logic [N_CELLS-1:0]     i_mis,
    input  wire logic [N_CELLS-1:0]     i_eq,
    input  wire logic [7:0]             i_cell_byte [N_CELLS],
    output ebcs_pkg::t_chain_ctl        o_ctl,
    output logic [FW-1:0]               o_fill,
    output logic [FW-1:0]               o_j,
    output logic [7:0]                  o_c,
    input  wire logic                   i_room,
    output ebcs_pkg::t_result           o_res
);
    import ebcs_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [POS_W-1:0] r_bytes_seen;
    logic [POS_W-1:0] n_bytes_seen;
    logic [POS_W-1:0] r_alignment;
    logic [POS_W-1:0] n_alignment;
    logic             r_answered;
    logic             n_answered;
    logic             r_last;
    logic             n_last;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    n_fill;
    logic [FW-1:0]    r_cnt;
    logic [FW-1:0]    n_cnt;
    logic [FW-1:0]    r_j;
    logic [FW-1:0]    n_j;
    logic [7:0]       r_c;
    logic [7:0]       n_c;
    logic [POS_W-1:0] r_res_pos;
    logic [POS_W-1:0] n_res_pos;
    logic             r_res_found;
    logic             n_res_found;

    logic             w_any_mis;
    logic [FW-1:0]    w_mis_j;
    logic [7:0]       w_mis_c;
    logic             w_any_eq;
    logic [FW-1:0]    w_eq_k;
    logic [FW-1:0]    w_skip;
    logic             w_full;

    // highest mismatching cell and its text byte
    always_comb begin
        w_any_mis = 1'b0;
        w_mis_j   = '0;
        w_mis_c   = 8'h00;
        for (int i = 0; i < N_CELLS; i++) begin
            if (i_mis[i]) begin
                w_any_mis = 1'b1;
                w_mis_j   = FW'(i);
                w_mis_c   = i_cell_byte[i];
            end
        end
    end

    // nearest equal pattern byte left of the mismatch
    always_comb begin
        w_any_eq = 1'b0;
        w_eq_k   = '0;
        for (int k = 0; k < N_CELLS; k++) begin
            if (i_eq[k]) begin
                w_any_eq = 1'b1;
                w_eq_k   = FW'(k);
            end
        end
    end

    assign w_skip = w_any_eq ? (r_j - w_eq_k) : (r_j + FW'(1));
    assign w_full = (r_fill >= i_m);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_answered) begin
                    if (i_m == '0) begin
                        n_state = S_FIN;
                    end else if (r_bytes_seen != POS_SAT) begin
                        n_state = S_CMP;
                    end else if (i_last_byte) begin
                        n_state = S_FIN;
                    end
                end
            end
            S_CMP: begin
                if (w_full) begin
                    n_state = w_any_mis ? S_BAD : S_FIN;
                end else begin
                    n_state = r_last ? S_FIN : S_IDLE;
                end
            end
            S_BAD: begin
                n_state = S_SHIFT;
            end
            S_SHIFT: begin
                if (r_cnt == FW'(1)) begin
                    n_state = S_CMP;
                end
            end
            S_FIN: begin
                if (i_room) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_bytes_seen    = r_bytes_seen;
        n_alignment     = r_alignment;
        n_answered      = r_answered;
        n_last          = r_last;
        n_fill          = r_fill;
        n_cnt           = r_cnt;
        n_j             = r_j;
        n_c             = r_c;
        n_res_pos       = r_res_pos;
        n_res_found     = r_res_found;
        o_ctl.load      = 1'b0;
        o_ctl.shift     = 1'b0;
        o_ctl.text_byte = i_text_byte;
        o_res.valid     = 1'b0;
        o_res.position  = r_res_pos;
        o_res.found     = r_res_found;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_last = i_last_byte;
                    if (r_answered) begin
                        if (i_last_byte) begin
                            n_bytes_seen = '0;
                            n_alignment  = '0;
                            n_answered   = 1'b0;
                            n_fill       = '0;
                        end
                    end else if (i_m == '0) begin
                        n_res_pos   = '0;
                        n_res_found = 1'b1;
                    end else if (r_bytes_seen != POS_SAT) begin
                        o_ctl.load   = 1'b1;
                        n_fill       = r_fill + FW'(1);
                        n_bytes_seen = r_bytes_seen + POS_W'(1);
                    end else begin
                        n_res_pos   = r_bytes_seen;
                        n_res_found = 1'b0;
                    end
                end
            end
            S_CMP: begin
                if (w_full) begin
                    if (w_any_mis) begin
                        n_j = w_mis_j;
                        n_c = w_mis_c;
                    end else begin
                        n_res_pos   = r_alignment;
                        n_res_found = 1'b1;
                    end
                end else if (r_last) begin
                    n_res_pos   = r_bytes_seen;
                    n_res_found = 1'b0;
                end
            end
            S_BAD: begin
                n_cnt = w_skip;
            end
            S_SHIFT: begin
                o_ctl.shift = 1'b1;
                n_fill      = r_fill - FW'(1);
                n_alignment = r_alignment + POS_W'(1);
                n_cnt       = r_cnt - FW'(1);
            end
            S_FIN: begin
                o_res.valid = 1'b1;
                if (i_room) begin
                    if (r_last) begin
                        n_bytes_seen = '0;
                        n_alignment  = '0;
                        n_answered   = 1'b0;
                        n_fill       = '0;
                    end else begin
                        n_answered = 1'b1;
                    end
                end
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
        // keep the answered flag while the window is not yet full
        if (r_state == S_CMP && !w_full && r_last) begin
            n_answered = r_answered;
        end else if (r_state == S_CMP && !w_full && !r_last) begin
            n_answered = r_answered;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bytes_seen <= '0;
            r_alignment  <= '0;
            r_answered   <= 1'b0;
            r_fill       <= '0;
            r_cnt        <= '0;
            r_last       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bytes_seen <= n_bytes_seen;
            r_alignment  <= n_alignment;
            r_answered   <= n_answered;
            r_fill       <= n_fill;
            r_cnt        <= n_cnt;
            r_last       <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j         <= n_j;
        r_c         <= n_c;
        r_res_pos   <= n_res_pos;
        r_res_found <= n_res_found;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_fill  = r_fill;
    assign o_j     = r_j;
    assign o_c     = r_c;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_cnt != '0) && (r_cnt <= r_fill))
        else $error("shift count out of range");

    a_shift_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |=> (r_alignment == $past(r_alignment) + POS_W'(1)))
        else $error("alignment did not advance on shift");

    a_miss_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.found) |-> r_last)
        else $error("length reported before last byte");

    a_align_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alignment <= r_bytes_seen)
        else $error("alignment beyond text");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(N_CELLS))
        else $error("window overfilled");

endmodule

`default_nettype wire

>>> sv/extended_bad_character_search.sv
// Top level of the streaming first-occurrence search with the extended bad-character rule.
//
// Usage: write pattern_len (index 0) and the pattern bytes (indexes 1 and 2) through
// i_cfg_we/i_cfg_index/i_cfg_data while the block is idle, then stream a text one byte per
// item on i_valid/o_stall, marking the final byte with i_last_byte. One result item per
// text leaves on o_valid/i_stall: the first match position with o_found high, or the text
// length with o_found low at the last byte. Items after a match are taken and dropped.
// Operation: the text sits in a row of cells aligned to the current alignment. Each item
// is loaded into the row and then compared; every mismatch first finds the skip, then
// shifts the row one cell a cycle, once per position of skip. A result then passes
// through the result stage on its way to the output register.
// The result sits in an output register and holds while i_stall is high; a second result
// then waits in the result stage and the input stalls until the register frees.
// Reset (synchronous, active low) clears the pattern registers, the text counters and
// the output valid; the window cells need no clearing.
`default_nettype none

module extended_bad_character_search #(
    parameter int MAX_PATTERN  = ebcs_pkg::MAX_PATTERN_DEF,
    parameter int WINDOW_DEPTH = ebcs_pkg::WINDOW_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [7:0]                    i_text_byte,
    input  wire logic                          i_last_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [ebcs_pkg::POS_W-1:0]         o_position,
    output logic                               o_found,
    input  wire logic                          i_cfg_we,
    input  wire logic [ebcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ebcs_pkg::CFG_W-1:0]    i_cfg_data
);
    import ebcs_pkg::*;

    localparam int N_CELLS = (MAX_PATTERN < WINDOW_DEPTH) ? MAX_PATTERN : WINDOW_DEPTH;
    localparam int FW      = $clog2(N_CELLS + 1);

    logic [4:0]       r_pattern_len;
    logic [CFG_W-1:0] r_pat_lo;
    logic [CFG_W-1:0] r_pat_hi;

    logic             r_ov;
    logic [POS_W-1:0] r_pos;
    logic             r_found;

    logic [FW-1:0]      w_m;
    logic [N_CELLS-1:0] w_mis;
    logic [N_CELLS-1:0] w_eq;
    logic [7:0]         w_cell_byte [N_CELLS];
    t_chain_ctl         w_ctl;
    logic [FW-1:0]      w_fill;
    logic [FW-1:0]      w_j;
    logic [7:0]         w_c;
    logic               w_room;
    t_result            w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_len <= '0;
            r_pat_lo      <= '0;
            r_pat_hi      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PATTERN_LEN:  r_pattern_len <= i_cfg_data[4:0];
                REG_PATTERN_LOW:  r_pat_lo      <= i_cfg_data;
                REG_PATTERN_HIGH: r_pat_hi      <= i_cfg_data;
                default: begin
                    r_pattern_len <= r_pattern_len;
                end
            endcase
        end
    end

    assign w_m = (32'(r_pattern_len) > 32'(N_CELLS)) ? FW'(N_CELLS) : FW'(r_pattern_len);

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        logic [7:0] w_pat;
        logic [7:0] w_next;

        if (g < 8) begin : g_lo
            assign w_pat = r_pat_lo[8*g +: 8];
        end else if (g < 16) begin : g_hi
            assign w_pat = r_pat_hi[8*(g-8) +: 8];
        end else begin : g_zero
            assign w_pat = 8'h00;
        end

        if (g < N_CELLS - 1) begin : g_link
            assign w_next = w_cell_byte[g+1];
        end else begin : g_end
            assign w_next = 8'h00;
        end

        ebcs_cell #(
            .IDX (g),
            .FW  (FW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_fill      (w_fill),
            .i_next_byte (w_next),
            .i_pat_byte  (w_pat),
            .i_m         (w_m),
            .i_j         (w_j),
            .i_c         (w_c),
            .o_byte      (w_cell_byte[g]),
            .o_mis       (w_mis[g]),
            .o_eq        (w_eq[g])
        );
    end

    ebcs_ctrl #(
        .N_CELLS (N_CELLS),
        .FW      (FW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_text_byte (i_text_byte),
        .i_last_byte (i_last_byte),
        .o_stall     (o_stall),
        .i_m         (w_m),
        .i_mis       (w_mis),
        .i_eq        (w_eq),
        .i_cell_byte (w_cell_byte),
        .o_ctl       (w_ctl),
        .o_fill      (w_fill),
        .o_j         (w_j),
        .o_c         (w_c),
        .i_room      (w_room),
        .o_res       (w_res)
    );

    assign w_room = !r_ov || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_room) begin
            r_ov <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_room && w_res.valid) begin
            r_pos   <= w_res.position;
            r_found <= w_res.found;
        end
    end

    assign o_valid    = r_ov;
    assign o_position = r_pos;
    assign o_found    = r_found;

endmodule

`default_nettype wire

>>> verif/tb_extended_bad_character_search.sv
// Testbench for the streaming bad-character search: directed and random texts checked live.
module tb_extended_bad_character_search;
    timeunit 1ns;
    timeprecision 1ps;

    import ebcs_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 200;
    localparam int STALL_LIMIT   = 5000;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
    } t_hit;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_text_byte = 8'd0;
    logic                 i_last_byte = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [POS_W-1:0]     o_position;
    logic                 o_found;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // mirror of the block
    logic [4:0]  pat_len = '0;
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [7:0]  text_window [WINDOW_DEPTH_DEF];
    int unsigned text_len = 0;
    int unsigned align_at = 0;
    bit          text_done = 1'b0;

    t_hit expected_hits [$];

    int  searched_items = 0;
    int  texts_sent = 0;
    int  hits_checked = 0;
    int  fail_count = 0;
    bit  steady = 1'b0;
    int  hold_req = 0;
    int  hold_left = 0;

    extended_bad_character_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_text_byte (i_text_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_position  (o_position),
        .o_found     (o_found),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] pat_at(input int unsigned k);
        if (k < 8) begin
            return pat_lo[8*k +: 8];
        end
        if (k < 16) begin
            return pat_hi[8*(k-8) +: 8];
        end
        return 8'd0;
    endfunction

    function automatic int unsigned pat_used();
        return (pat_len > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : int'(pat_len);
    endfunction

    function automatic logic [7:0] pick_byte(input int span);
        if (span >= 256) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'h41 + 8'($urandom_range(0, span - 1));
    endfunction

    function automatic void queue_hit(input logic [POS_W-1:0] pos, input logic fnd);
        expected_hits.insert(expected_hits.size(), t_hit'{pos, fnd});
    endfunction

    // advance the search by one text byte and queue any result it causes
    function automatic void search_step(input logic [7:0] b, input logic last);
        int unsigned m, p, j, k, jm, step_by;
        logic [7:0]  c;
        bit          miss, hit_left;
        m = pat_used();
        searched_items++;
        if (!text_done) begin
            if (m == 0) begin
                queue_hit(16'd0, 1'b1);
                text_done = 1'b1;
            end else if (text_len < 65535) begin
                p = text_len;
                text_window[p % WINDOW_DEPTH_DEF] = b;
                text_len = p + 1;
                while (align_at + m - 1 <= p && !text_done) begin
                    j = m;
                    miss = 1'b0;
                    while (j > 0 && !miss) begin
                        if (pat_at(j - 1) != text_window[(align_at + j - 1) % WINDOW_DEPTH_DEF])
                            miss = 1'b1;
                        else
                            j--;
                    end
                    if (!miss) begin
                        queue_hit(align_at[15:0], 1'b1);
                        text_done = 1'b1;
                    end else begin
                        jm = j - 1;
                        c = text_window[(align_at + jm) % WINDOW_DEPTH_DEF];
                        step_by = jm + 1;
                        k = jm;
                        hit_left = 1'b0;
                        while (k > 0 && !hit_left) begin
                            if (pat_at(k - 1) == c) begin
                                step_by = jm - (k - 1);
                                hit_left = 1'b1;
                            end else begin
                                k--;
                            end
                        end
                        align_at += step_by;
                    end
                end
            end
            if (last && !text_done) begin
                queue_hit(text_len[15:0], 1'b0);
            end
        end
        if (last) begin
            text_len = 0;
            align_at = 0;
            text_done = 1'b0;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        search_step(b, last);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_hits.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_pattern(input logic [4:0] len, input logic [63:0] lo,
                                input logic [63:0] hi, input bit poke_spare);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_W-1:0]     val [4];
        int                   n;
        idx[0] = REG_PATTERN_LEN;
        val[0] = {$urandom(), $urandom()};
        val[0][4:0] = len;
        idx[1] = REG_PATTERN_LOW;
        val[1] = lo;
        idx[2] = REG_PATTERN_HIGH;
        val[2] = hi;
        idx[3] = REG_SPARE;
        val[3] = {$urandom(), $urandom()};
        n = poke_spare ? 4 : 3;
        for (int i = 0; i < n; i++) begin
            if (i > 0) @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(posedge i_clk);
            case (idx[i])
                REG_PATTERN_LEN:  pat_len = val[i][4:0];
                REG_PATTERN_LOW:  pat_lo = val[i];
                REG_PATTERN_HIGH: pat_hi = val[i];
                default: ;
            endcase
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_pattern(input int len, input int span, input bit poke_spare);
        logic [63:0] lo, hi;
        for (int k = 0; k < 8; k++) begin
            lo[8*k +: 8] = pick_byte(span);
            hi[8*k +: 8] = pick_byte(span);
        end
        load_pattern(5'(len), lo, hi, poke_spare);
    endtask

    task automatic send_text(input int len, input int span, input bit plant);
        logic [7:0]  txt [64];
        int unsigned m;
        int          at;
        for (int i = 0; i < len; i++) txt[i] = pick_byte(span);
        m = pat_used();
        if (plant && m > 0 && m <= len) begin
            at = $urandom_range(0, len - m);
            for (int i = 0; i < m; i++) txt[at + i] = pat_at(i);
        end
        for (int i = 0; i < len; i++) send_byte(txt[i], i == len - 1);
        texts_sent++;
    endtask

    task automatic test_directed();
        load_pattern(5'd0, {$urandom(), $urandom()}, {$urandom(), $urandom()}, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_idle();
        load_pattern(5'd1, 64'h0000_0000_0000_00FF, 64'd0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_idle();
        load_pattern(5'd3, 64'h0000_0000_0043_4241, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_byte(8'h58, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h43, 1'b1);
        send_byte(8'h41, 1'b0);
        send_byte(8'h42, 1'b0);
        send_byte(8'h44, 1'b1);
        texts_sent += 6;
    endtask

    task automatic test_short_patterns();
        int goal;
        int span;
        goal = searched_items + 400;
        while (searched_items < goal) begin
            wait_idle();
            span = $urandom_range(2, 4);
            set_pattern($urandom_range(1, 8), span, 1'b0);
            repeat (6) send_text($urandom_range(1, 40), span, $urandom_range(0, 9) < 6);
        end
    endtask

    task automatic test_long_patterns();
        int goal;
        int round;
        int len;
        int span;
        goal = searched_items + 350;
        round = 0;
        while (searched_items < goal) begin
            wait_idle();
            case (round)
                0: len = 16;
                1: len = 17;
                2: len = 31;
                default: len = $urandom_range(9, 31);
            endcase
            span = $urandom_range(2, 3);
            set_pattern(len, span, round == 3);
            repeat (5) send_text($urandom_range(1, 64), span, $urandom_range(0, 9) < 6);
            round++;
        end
    endtask

    task automatic test_noise_bytes();
        int goal;
        int round;
        goal = searched_items + 200;
        round = 0;
        while (searched_items < goal) begin
            wait_idle();
            case (round)
                0: load_pattern(5'd16, '1, '1, 1'b0);
                1: load_pattern(5'd5, '0, '0, 1'b0);
                default: set_pattern($urandom_range(0, 16), 256, 1'b0);
            endcase
            repeat (5) send_text($urandom_range(1, 40), 256, $urandom_range(0, 1));
            round++;
        end
    endtask

    task automatic test_steady_stream();
        int goal;
        wait_idle();
        steady = 1'b1;
        set_pattern($urandom_range(1, 6), 3, 1'b0);
        goal = searched_items + 100;
        while (searched_items < goal) send_text($urandom_range(1, 30), 3, $urandom_range(0, 1));
        wait_idle();
        steady = 1'b0;
    endtask

    task automatic test_result_backpressure();
        wait_idle();
        load_pattern(5'd2, 64'h0000_0000_0000_4241, 64'd0, 1'b0);
        hold_req = 400;
        while (hold_left == 0) @(negedge i_clk);
        repeat (5) send_text(12, 3, 1'b1);
        wait_idle();
        repeat (3) send_text($urandom_range(2, 20), 3, 1'b1);
    endtask

    initial begin : result_backpressure
        forever begin
            @(negedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !steady && $urandom_range(0, 99) < 13;
            end
        end
    end

    initial begin : result_check
        t_hit want;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                if (expected_hits.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: position %0d found %0b",
                                 o_position, o_found);
                end else begin
                    want = expected_hits.pop_front();
                    hits_checked++;
                    if (want.position !== o_position || want.found !== o_found) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: position exp %0d got %0d, found exp %0b got %0b",
                                     want.position, o_position, want.found, o_found);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("no progress for %0d cycles", quiet);
        $display("[extended_bad_character_search] ERROR");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_short_patterns();
        test_long_patterns();
        test_noise_bytes();
        test_steady_stream();
        test_result_backpressure();
        wait_idle();
        $display("%0d texts, %0d bytes sent, %0d results checked, %0d failures",
                 texts_sent, searched_items, hits_checked, fail_count);
        $display("pattern lengths 0 to 31, full byte range, steady stream, back-pressure");
        if (fail_count == 0 && expected_hits.size() == 0) begin
            $display("[extended_bad_character_search] OK");
        end else begin
            $display("[extended_bad_character_search] ERROR");
        end
        $finish;
    end

endmodule
